// ===== design/sorted_unique_set_table_defines.svh =====
// Assertion macros for the sorted set table RTL.
// No dependencies; included by sust_ctrl, the module that carries assertions.
`ifndef SORTED_UNIQUE_SET_TABLE_DEFINES_SVH
`define SORTED_UNIQUE_SET_TABLE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SUST_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SUST_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/sust_pkg.sv =====
// Types and codes for the sorted set table.
// No dependencies; used by every module of the block.
package sust_pkg;

   // Request operation codes.
   typedef enum logic [2:0] {
      OP_INSERT = 3'd0,
      OP_REMOVE = 3'd1,
      OP_TEST   = 3'd2,
      OP_CLEAR  = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_BAD_INDEX = 2'd2
   } status_type;

   // Where a travelling token stands in its walk down the row.
   typedef enum logic [1:0] {
      PH_SEEK  = 2'd0,
      PH_SHIFT = 2'd1,
      PH_DONE  = 2'd2
   } phase_type;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_RUN  = 2'd1,
      S_WAIT = 2'd2
   } state_type;

   // Number of distinct read positions the request can name.
   localparam int POS_SPAN = 256;

   typedef struct packed {
      logic [2:0]  operation;
      logic [15:0] value;
      logic [7:0]  position;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [8:0]  entry_count;
      logic [15:0] read_value;
      logic [15:0] largest_seen;
      logic [1:0]  status;
   } rsp_type;

   // Control part of the token that walks the row of cells.
   typedef struct packed {
      logic      live;
      op_type    op;
      phase_type phase;
      logic      found;
      logic [7:0] pos;
   } tok_ctl_type;

endpackage

// ===== design/sust_cell.sv =====
// One cell of the sorted set row: holds one entry and its valid bit.
// Depends on sust_pkg; instantiated in a chain by sorted_unique_set_table.
module sust_cell #(
   parameter int VAL_W      = 16,
   parameter int CELL_INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear_all,
   input  sust_pkg::tok_ctl_type tok_ctl_in,
   input  logic [VAL_W-1:0]      tok_val_in,
   input  logic [VAL_W-1:0]      tok_carry_in,
   input  logic [VAL_W-1:0]      tok_rd_in,
   input  logic [VAL_W-1:0]      next_entry,
   input  logic                  next_valid,
   output logic [VAL_W-1:0]      entry,
   output logic                  entry_valid,
   output sust_pkg::tok_ctl_type tok_ctl_out,
   output logic [VAL_W-1:0]      tok_val_out,
   output logic [VAL_W-1:0]      tok_carry_out,
   output logic [VAL_W-1:0]      tok_rd_out
);
   import sust_pkg::*;

   logic [VAL_W-1:0] entry_ff, entry_in;
   logic             valid_ff, valid_in;
   tok_ctl_type      tok_ctl_ff, tok_ctl_in_nx;
   logic [VAL_W-1:0] tok_val_ff;
   logic [VAL_W-1:0] tok_carry_ff, tok_carry_in_nx;
   logic [VAL_W-1:0] tok_rd_ff, tok_rd_in_nx;
   logic             less, equal, pos_hit;

   assign less    = valid_ff && (entry_ff < tok_val_in);
   assign equal   = valid_ff && (entry_ff == tok_val_in);
   assign pos_hit = (CELL_INDEX < POS_SPAN) && (tok_ctl_in.pos == 8'(CELL_INDEX));

   always_comb begin
      entry_in        = entry_ff;
      valid_in        = valid_ff;
      tok_ctl_in_nx   = tok_ctl_in;
      tok_carry_in_nx = tok_carry_in;
      tok_rd_in_nx    = tok_rd_in;
      if (tok_ctl_in.live) begin
         case (tok_ctl_in.op) inside
            OP_INSERT: begin
               if (tok_ctl_in.phase == PH_SEEK) begin
                  if (equal) begin
                     tok_ctl_in_nx.found = 1'b1;
                     tok_ctl_in_nx.phase = PH_DONE;
                  end else if (!less) begin
                     // This is the sorted slot: take the new value, push ours on.
                     entry_in            = tok_val_in;
                     valid_in            = 1'b1;
                     tok_carry_in_nx     = entry_ff;
                     tok_ctl_in_nx.phase = valid_ff ? PH_SHIFT : PH_DONE;
                  end
               end else if (tok_ctl_in.phase == PH_SHIFT) begin
                  entry_in        = tok_carry_in;
                  valid_in        = 1'b1;
                  tok_carry_in_nx = entry_ff;
                  if (!valid_ff) begin
                     tok_ctl_in_nx.phase = PH_DONE;
                  end
               end
            end
            OP_REMOVE: begin
               if (tok_ctl_in.phase == PH_SEEK) begin
                  if (equal) begin
                     tok_ctl_in_nx.found = 1'b1;
                     tok_ctl_in_nx.phase = PH_SHIFT;
                     entry_in            = next_entry;
                     valid_in            = next_valid;
                  end else if (!less) begin
                     tok_ctl_in_nx.phase = PH_DONE;
                  end
               end else if (tok_ctl_in.phase == PH_SHIFT) begin
                  // The neighbor has not seen this token yet, so it still
                  // holds its old entry.
                  entry_in = next_entry;
                  valid_in = next_valid;
                  if (!next_valid) begin
                     tok_ctl_in_nx.phase = PH_DONE;
                  end
               end
            end
            OP_TEST, OP_CLEAR: begin
               if (tok_ctl_in.phase == PH_SEEK) begin
                  if (equal) begin
                     tok_ctl_in_nx.found = 1'b1;
                     tok_ctl_in_nx.phase = PH_DONE;
                  end else if (!less) begin
                     tok_ctl_in_nx.phase = PH_DONE;
                  end
               end
            end
            OP_READ: begin
               if (pos_hit && valid_ff) begin
                  tok_rd_in_nx = entry_ff;
               end
            end
            default: begin
            end
         endcase
      end
      if (clear_all) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         tok_ctl_ff <= '0;
      end else begin
         valid_ff   <= valid_in;
         tok_ctl_ff <= tok_ctl_in_nx;
      end
      entry_ff     <= entry_in;
      tok_val_ff   <= tok_val_in;
      tok_carry_ff <= tok_carry_in_nx;
      tok_rd_ff    <= tok_rd_in_nx;
   end

   assign entry         = entry_ff;
   assign entry_valid   = valid_ff;
   assign tok_ctl_out   = tok_ctl_ff;
   assign tok_val_out   = tok_val_ff;
   assign tok_carry_out = tok_carry_ff;
   assign tok_rd_out    = tok_rd_ff;

endmodule

// ===== design/sust_ctrl.sv =====
// Controller of the sorted set table: request and response registers,
// entry count, largest value and the token that is sent down the cell row.
// Depends on sust_pkg and sorted_unique_set_table_defines.svh.
`include "sorted_unique_set_table_defines.svh"
module sust_ctrl #(
   parameter int CAPACITY = 256,
   parameter int VAL_W    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sust_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sust_pkg::rsp_type     rsp_data,
   output sust_pkg::tok_ctl_type head_ctl,
   output logic [VAL_W-1:0]      head_val,
   input  sust_pkg::tok_ctl_type tail_ctl,
   input  logic [VAL_W-1:0]      tail_rd,
   output logic                  clear_all
);
   import sust_pkg::*;

   localparam int CNT_BITS = $clog2(CAPACITY + 1);

   state_type            state_ff, state_in;
   req_type              req_ff;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [VAL_W-1:0]     largest_ff, largest_in;
   rsp_type              pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff;
   tok_ctl_type          tok_ctl_ff, tok_ctl_in;
   logic [VAL_W-1:0]     tok_val_ff;
   logic [VAL_W-1:0]     req_val;
   logic                 accept, tail_done, rsp_free, load_rsp, table_full;
   op_type               req_op, cur_op;
   status_type           status_val;
   logic [VAL_W-1:0]     rd_val;

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign table_full = (count_ff == CNT_BITS'(CAPACITY));
   assign req_val    = req_data.value[VAL_W-1:0];
   assign req_op     = op_type'(req_data.operation);
   assign cur_op     = op_type'(req_ff.operation);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (tail_ctl.live) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      req_stall = 1'b1;
      tail_done = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
         end
         S_RUN: begin
            tail_done = tail_ctl.live;
         end
         S_WAIT: begin
            load_rsp = rsp_free;
         end
         default: begin
         end
      endcase
   end

   assign accept    = req_valid && !req_stall;
   assign clear_all = tail_done && (cur_op == OP_CLEAR);

   // Token launch.
   always_comb begin
      tok_ctl_in = '0;
      if (accept) begin
         tok_ctl_in.live  = 1'b1;
         // An insert into a full table only looks the value up.
         tok_ctl_in.op    = (req_op == OP_INSERT && table_full) ? OP_TEST : req_op;
         tok_ctl_in.phase = PH_SEEK;
         tok_ctl_in.found = 1'b0;
         tok_ctl_in.pos   = req_data.position;
      end
   end

   // Completion: update count and largest, build the response.
   always_comb begin
      count_in   = count_ff;
      largest_in = largest_ff;
      status_val = ST_OK;
      rd_val     = '0;
      pend_in    = pend_ff;
      if (tail_done) begin
         case (cur_op)
            OP_INSERT: begin
               if (!tail_ctl.found) begin
                  if (table_full) begin
                     status_val = ST_FULL;
                  end else begin
                     count_in = count_ff + CNT_BITS'(1);
                     if (req_ff.value[VAL_W-1:0] > largest_ff) begin
                        largest_in = req_ff.value[VAL_W-1:0];
                     end
                  end
               end
            end
            OP_REMOVE: begin
               if (tail_ctl.found) begin
                  count_in = count_ff - CNT_BITS'(1);
               end
            end
            OP_CLEAR: begin
               count_in   = '0;
               largest_in = '0;
            end
            OP_READ: begin
               if (32'(req_ff.position) >= 32'(count_ff)) begin
                  status_val = ST_BAD_INDEX;
               end else begin
                  rd_val = tail_rd;
               end
            end
            default: begin
            end
         endcase
         pend_in.found = (cur_op == OP_INSERT || cur_op == OP_REMOVE ||
                          cur_op == OP_TEST || cur_op == OP_CLEAR) && tail_ctl.found;
         pend_in.entry_count  = 9'(count_in);
         pend_in.read_value   = 16'(rd_val);
         pend_in.largest_seen = 16'(largest_in);
         pend_in.status       = status_val;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         largest_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         tok_ctl_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         largest_ff   <= largest_in;
         rsp_valid_ff <= rsp_valid_in;
         tok_ctl_ff   <= tok_ctl_in;
      end
      if (accept) begin
         req_ff     <= req_data;
         tok_val_ff <= req_val;
      end
      pend_ff <= pend_in;
      if (load_rsp) begin
         rsp_data_ff <= pend_ff;
      end
   end

   assign head_ctl  = tok_ctl_ff;
   assign head_val  = tok_val_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SUST_ASSERT_NOW(a_tail_only_when_running, tail_ctl.live, state_ff == S_RUN,
      "token reached the end of the row while no request was running")
   `SUST_ASSERT_NOW(a_count_in_range, 1'b1, count_ff <= CNT_BITS'(CAPACITY),
      "entry count exceeds capacity")
   `SUST_ASSERT_NEXT(a_count_moves_at_end, !tail_done, $stable(count_ff),
      "entry count changed outside request completion")

endmodule

// ===== design/sorted_unique_set_table.sv =====
// Top level of the sorted set table: controller plus a row of cells.
// Depends on sust_pkg, sust_ctrl and sust_cell.
//
//   Channel   Ports                          Direction  Payload
//   request   req_valid req_stall req_data   in         sust_pkg::req_type
//   response  rsp_valid rsp_stall rsp_data   out        sust_pkg::rsp_type
//
// After a request transfer the controller registers the token, which then walks
// the CAPACITY cells one per cycle; the controller then records the result,
// loads the response register once the response side is free and returns to
// idle to take the next request.
// Reset clears all valid bits, the count and the largest value.
// One finished response is buffered; the next request is taken while it waits.
// A stalled response holds the controller only after a second request finishes.
module sorted_unique_set_table #(
   parameter int CAPACITY   = 256,
   parameter int VALUE_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sust_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sust_pkg::rsp_type rsp_data
);
   import sust_pkg::*;

   // The request value field is 16 bits wide, so no stored bit can exceed that.
   localparam int VAL_W = (VALUE_BITS < 16) ? VALUE_BITS : 16;

   // Token and entry wiring along the row. Index i of the token arrays is
   // the input of cell i; index CAPACITY is the end of the row.
   tok_ctl_type      tok_ctl   [CAPACITY+1];
   logic [VAL_W-1:0] tok_val   [CAPACITY+1];
   logic [VAL_W-1:0] tok_carry [CAPACITY+1];
   logic [VAL_W-1:0] tok_rd    [CAPACITY+1];
   logic [VAL_W-1:0] cell_entry [CAPACITY];
   logic             cell_valid [CAPACITY];
   logic             clear_all;

   sust_ctrl #(
      .CAPACITY (CAPACITY),
      .VAL_W    (VAL_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .head_ctl  (tok_ctl[0]),
      .head_val  (tok_val[0]),
      .tail_ctl  (tok_ctl[CAPACITY]),
      .tail_rd   (tok_rd[CAPACITY]),
      .clear_all (clear_all)
   );

   // The token enters the row with nothing carried and nothing read.
   assign tok_carry[0] = '0;
   assign tok_rd[0]    = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VAL_W-1:0] nbr_entry;
      logic             nbr_valid;

      // The last cell sees an empty neighbor, so a removal shifts in nothing.
      if (i == CAPACITY - 1) begin : g_last
         assign nbr_entry = '0;
         assign nbr_valid = 1'b0;
      end else begin : g_inner
         assign nbr_entry = cell_entry[i+1];
         assign nbr_valid = cell_valid[i+1];
      end

      sust_cell #(
         .VAL_W      (VAL_W),
         .CELL_INDEX (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .clear_all     (clear_all),
         .tok_ctl_in    (tok_ctl[i]),
         .tok_val_in    (tok_val[i]),
         .tok_carry_in  (tok_carry[i]),
         .tok_rd_in     (tok_rd[i]),
         .next_entry    (nbr_entry),
         .next_valid    (nbr_valid),
         .entry         (cell_entry[i]),
         .entry_valid   (cell_valid[i]),
         .tok_ctl_out   (tok_ctl[i+1]),
         .tok_val_out   (tok_val[i+1]),
         .tok_carry_out (tok_carry[i+1]),
         .tok_rd_out    (tok_rd[i+1])
      );
   end

endmodule
